/* rtl/plfd_pkg.sv */
// ----------------------------------------------------------------------------
// plfd_pkg
// Shared types and constants of the point list delta decoder: the token that
// travels from the byte front end to the delta back end, the back end phases,
// the direction codes and the error codes.
// ----------------------------------------------------------------------------
package plfd_pkg;

    localparam int unsigned VALUE_W = 64;

    typedef struct packed {
        logic               restart;
        logic               overlong;
        logic [VALUE_W-1:0] value;
    } plfd_token_t;

    typedef enum logic [4:0] {
        PH_TYPE  = 5'b00001,
        PH_COUNT = 5'b00010,
        PH_DELTA = 5'b00100,
        PH_DY    = 5'b01000,
        PH_HALT  = 5'b10000
    } plfd_phase_t;

    localparam logic [2:0] DIR_E  = 3'd0;
    localparam logic [2:0] DIR_N  = 3'd1;
    localparam logic [2:0] DIR_W  = 3'd2;
    localparam logic [2:0] DIR_S  = 3'd3;
    localparam logic [2:0] DIR_NE = 3'd4;
    localparam logic [2:0] DIR_NW = 3'd5;
    localparam logic [2:0] DIR_SW = 3'd6;
    localparam logic [2:0] DIR_SE = 3'd7;

    localparam logic [2:0] TYPE_ONEAXIS_V = 3'd1;
    localparam logic [2:0] TYPE_DIR2      = 3'd2;
    localparam logic [2:0] TYPE_DIR3      = 3'd3;
    localparam logic [VALUE_W-1:0] TYPE_LIMIT = 64'd6;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_TYPE = 2'd1;
    localparam logic [1:0] ERR_OVERLONG = 2'd2;

endpackage

/* rtl/point_list_delta_decoder.sv */
// ----------------------------------------------------------------------------
// point_list_delta_decoder
// Decodes a byte stream holding layout point lists into dx,dy deltas.
//
// The s_ channel takes one encoded byte per beat, with s_list_start marking
// the first byte of a new list. The m_ channel gives one dx,dy beat per
// decoded delta, with m_last_delta on the final delta of a list and
// m_error_code flagging an unknown list type or an overlong varint; after an
// error the decoder drops bytes until the next list start.
// One byte is taken per cycle while s_ready is high. A byte that completes a
// delta reaches the m_ channel as follows: the front end pushes its token
// into the two-entry token queue as the byte is accepted, and the back end
// moves it into the output register once that register is free.
// While m_ready is low the output beat holds, and the front end keeps taking
// bytes until the token queue is full, after which s_ready drops.
// Reset empties the queue and clears the output valid flag, and leaves the
// decoder waiting for a list type.
// ----------------------------------------------------------------------------
module point_list_delta_decoder #(
    parameter int unsigned MAX_VARINT_BYTES = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_list_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_dx,
    output logic signed [63:0] m_dy,
    output logic               m_last_delta,
    output logic [1:0]         m_error_code
);
    import plfd_pkg::*;

    logic        q_full;
    logic        push;
    plfd_token_t push_token;
    logic        head_valid;
    plfd_token_t head_token;
    logic        pop;
    logic [63:0] dx_bits;
    logic [63:0] dy_bits;

    assign s_ready = !q_full;

    plfd_front #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_accept(s_valid && s_ready),
        .data_byte  (s_data_byte),
        .list_start (s_list_start),
        .push       (push),
        .push_token (push_token)
    );

    plfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_token(push_token),
        .full      (q_full),
        .head_valid(head_valid),
        .head_token(head_token),
        .pop       (pop)
    );

    plfd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_token  (head_token),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dx        (dx_bits),
        .m_dy        (dy_bits),
        .m_last_delta(m_last_delta),
        .m_error_code(m_error_code)
    );

    assign m_dx = $signed(dx_bits);
    assign m_dy = $signed(dy_bits);

endmodule

/* rtl/plfd_front.sv */
// ----------------------------------------------------------------------------
// plfd_front
// Byte front end. Gathers 7-bit groups into one varint and pushes a token for
// every completed or overlong varint. A list start mark travels with the next
// token so the back end restarts its list in step with the bytes.
// ----------------------------------------------------------------------------
module plfd_front #(
    parameter int unsigned MAX_VARINT_BYTES = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           data_byte,
    input  logic                 list_start,
    output logic                 push,
    output plfd_pkg::plfd_token_t push_token
);
    import plfd_pkg::*;

    localparam int unsigned OVER_SHIFT = 7 * (MAX_VARINT_BYTES - 1);

    logic [VALUE_W-1:0] accum_reg, accum_next;
    logic [6:0]         shift_reg, shift_next;
    logic               restart_reg, restart_next;

    logic [VALUE_W-1:0] base_accum;
    logic [6:0]         base_shift;
    logic               restart_cur;
    logic [VALUE_W-1:0] group_bits;
    logic [VALUE_W-1:0] value_cur;
    logic               too_long;

    always_comb begin
        base_accum  = list_start ? '0 : accum_reg;
        base_shift  = list_start ? 7'd0 : shift_reg;
        restart_cur = list_start | restart_reg;
        group_bits  = {{(VALUE_W-7){1'b0}}, data_byte[6:0]} << base_shift[5:0];
        value_cur   = base_accum | group_bits;
        too_long    = base_shift >= 7'(OVER_SHIFT);

        accum_next   = accum_reg;
        shift_next   = shift_reg;
        restart_next = restart_reg;
        push         = 1'b0;
        push_token.restart  = restart_cur;
        push_token.overlong = too_long;
        push_token.value    = value_cur;

        if (byte_accept) begin
            if (data_byte[7] && !too_long) begin
                accum_next   = value_cur;
                shift_next   = base_shift + 7'd7;
                restart_next = restart_cur;
            end else begin
                push         = 1'b1;
                accum_next   = '0;
                shift_next   = 7'd0;
                restart_next = 1'b0;
            end
        end
        if (!data_byte[7]) begin
            push_token.overlong = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg   <= '0;
            shift_reg   <= 7'd0;
            restart_reg <= 1'b0;
        end else begin
            accum_reg   <= accum_next;
            shift_reg   <= shift_next;
            restart_reg <= restart_next;
        end
    end

endmodule

/* rtl/plfd_queue.sv */
// ----------------------------------------------------------------------------
// plfd_queue
// Two-entry token queue between the front end and the back end, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module plfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  plfd_pkg::plfd_token_t push_token,
    output logic                  full,
    output logic                  head_valid,
    output plfd_pkg::plfd_token_t head_token,
    input  logic                  pop
);
    import plfd_pkg::*;

    plfd_token_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb begin
        full        = count_reg == 2'd2;
        head_valid  = count_reg != 2'd0;
        head_token  = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("Token pushed into a full queue.");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("Token popped from an empty queue.");

    a_count_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("Queue pointers disagree with the fill count.");

endmodule

/* rtl/plfd_back.sv */
// ----------------------------------------------------------------------------
// plfd_back
// Delta back end. Interprets each varint token by list phase and type and
// writes one dx,dy beat into the output register per decoded delta or error.
// ----------------------------------------------------------------------------
module plfd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  plfd_pkg::plfd_token_t head_token,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [63:0]           m_dx,
    output logic [63:0]           m_dy,
    output logic                  m_last_delta,
    output logic [1:0]            m_error_code
);
    import plfd_pkg::*;

    plfd_phase_t        phase_reg, phase_next, phase_cur;
    logic [2:0]         type_reg, type_next;
    logic               horiz_reg, horiz_next;
    logic [VALUE_W-1:0] left_reg, left_next;
    logic [VALUE_W-1:0] pend_reg, pend_next;

    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] dx_reg, dx_next;
    logic [VALUE_W-1:0] dy_reg, dy_next;
    logic               last_reg, last_next;
    logic [1:0]         err_reg, err_next;

    logic [VALUE_W-1:0] v;
    logic [2:0]         dir;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] neg;
    logic [VALUE_W-1:0] xs, ys;
    logic               emit;
    logic               final_delta;

    always_comb begin
        v         = head_token.value;
        phase_cur = head_token.restart ? PH_TYPE : phase_reg;

        if (phase_cur == PH_DY) begin
            dir = v[0] ? DIR_S : DIR_N;
            mag = v >> 1;
        end else if (type_reg <= TYPE_ONEAXIS_V) begin
            if (horiz_reg) begin
                dir = v[0] ? DIR_W : DIR_E;
            end else begin
                dir = v[0] ? DIR_S : DIR_N;
            end
            mag = v >> 1;
        end else if (type_reg == TYPE_DIR2) begin
            dir = {1'b0, v[1:0]};
            mag = v >> 2;
        end else if (type_reg == TYPE_DIR3) begin
            dir = v[2:0];
            mag = v >> 3;
        end else if (!v[0]) begin
            dir = v[3:1];
            mag = v >> 4;
        end else begin
            dir = v[1] ? DIR_W : DIR_E;
            mag = v >> 2;
        end
        neg = '0 - mag;

        case (dir)
            DIR_E: begin
                xs = mag;
                ys = '0;
            end
            DIR_N: begin
                xs = '0;
                ys = mag;
            end
            DIR_W: begin
                xs = neg;
                ys = '0;
            end
            DIR_S: begin
                xs = '0;
                ys = neg;
            end
            DIR_NE: begin
                xs = mag;
                ys = mag;
            end
            DIR_NW: begin
                xs = neg;
                ys = mag;
            end
            DIR_SW: begin
                xs = neg;
                ys = neg;
            end
            default: begin
                xs = mag;
                ys = neg;
            end
        endcase

        pop         = head_valid && (!m_valid_reg || m_ready);
        final_delta = left_reg == 64'd1;

        phase_next = phase_reg;
        type_next  = type_reg;
        horiz_next = horiz_reg;
        left_next  = left_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        dx_next    = xs;
        dy_next    = ys;
        last_next  = final_delta;
        err_next   = ERR_NONE;

        if (pop) begin
            phase_next = phase_cur;
            if (head_token.restart) begin
                left_next = '0;
            end
            if (phase_cur == PH_HALT) begin
                phase_next = PH_HALT;
            end else if (head_token.overlong) begin
                phase_next = PH_HALT;
                emit       = 1'b1;
                dx_next    = '0;
                dy_next    = '0;
                last_next  = 1'b1;
                err_next   = ERR_OVERLONG;
            end else begin
                case (phase_cur)
                    PH_TYPE: begin
                        if (v >= TYPE_LIMIT) begin
                            phase_next = PH_HALT;
                            emit       = 1'b1;
                            dx_next    = '0;
                            dy_next    = '0;
                            last_next  = 1'b1;
                            err_next   = ERR_BAD_TYPE;
                        end else begin
                            type_next  = v[2:0];
                            horiz_next = v == '0;
                            phase_next = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        left_next  = v;
                        phase_next = (v == '0) ? PH_TYPE : PH_DELTA;
                    end
                    PH_DELTA: begin
                        if (type_reg > TYPE_DIR3 && v[0]) begin
                            pend_next  = xs;
                            phase_next = PH_DY;
                        end else begin
                            emit       = 1'b1;
                            left_next  = left_reg - 64'd1;
                            phase_next = final_delta ? PH_TYPE : PH_DELTA;
                            if (type_reg <= TYPE_ONEAXIS_V) begin
                                horiz_next = ~horiz_reg;
                            end
                        end
                    end
                    default: begin
                        emit       = 1'b1;
                        dx_next    = pend_reg;
                        left_next  = left_reg - 64'd1;
                        phase_next = final_delta ? PH_TYPE : PH_DELTA;
                    end
                endcase
            end
        end

        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TYPE;
            type_reg    <= 3'd0;
            horiz_reg   <= 1'b0;
            left_reg    <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            horiz_reg   <= horiz_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dx         = dx_reg;
    assign m_dy         = dy_reg;
    assign m_last_delta = last_reg;
    assign m_error_code = err_reg;

endmodule

/* dv/tb_point_list_delta_decoder.sv */
// ----------------------------------------------------------------------------
// tb_point_list_delta_decoder
// Self-checking testbench for the point list delta decoder. A byte stream of
// point lists is built up front: a short hand-written stream, then random
// lists of every type, most of them well formed, the rest with bad types,
// overlong varints, cut-off lists and stray bytes. Each accepted byte goes
// through a scoreboard that decodes the stream the same way the block should.
// Every delta beat on the output is checked field by field against the oldest
// decoded delta. The sender goes in bursts with gaps, and the receiver stalls
// in patterns, including one long hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_point_list_delta_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import plfd_pkg::*;

    localparam int          MAX_VARINT_BYTES   = 10;
    localparam int          CYCLE_LIMIT        = 100000;
    localparam int          RANDOM_BYTES       = 1250;
    localparam int          HOLD_AT            = 300;
    localparam int          HOLD_LEN           = 250;
    localparam int          TAIL_CYCLES        = 16;
    localparam logic [2:0]  TYPE_ONEAXIS_H     = 3'd0;
    localparam logic [2:0]  TYPE_GENERAL_FIRST = 3'd4;
    localparam logic [2:0]  TYPE_GENERAL_LAST  = 3'd5;

    typedef struct {
        logic [63:0] dx;
        logic [63:0] dy;
        logic        last;
        logic [1:0]  err;
    } delta_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stream_byte_t;

    class delta_scoreboard;
        plfd_phase_t dec_phase;
        logic [2:0]  list_type;
        logic [63:0] deltas_left;
        logic [63:0] group_sum;
        logic [6:0]  group_shift;
        logic        horizontal_next;
        logic [63:0] pending_dx;
        delta_beat_t due_deltas[$];
        int          n_fail;
        int          n_checked;
        int          n_bad_type;
        int          n_overlong;

        function new();
            dec_phase       = PH_TYPE;
            list_type       = '0;
            deltas_left     = '0;
            group_sum       = '0;
            group_shift     = '0;
            horizontal_next = 1'b0;
            pending_dx      = '0;
            n_fail          = 0;
            n_checked       = 0;
            n_bad_type      = 0;
            n_overlong      = 0;
        endfunction

        function int outstanding();
            return due_deltas.size();
        endfunction

        function logic [63:0] sign_mag(input logic [63:0] v);
            return v[0] ? -(v >> 1) : (v >> 1);
        endfunction

        function void dir_offsets(input logic [2:0] dir, input logic [63:0] m,
                                  output logic [63:0] x, output logic [63:0] y);
            logic [63:0] n;
            n = -m;
            case (dir)
                DIR_E:   begin x = m; y = '0; end
                DIR_N:   begin x = '0; y = m; end
                DIR_W:   begin x = n; y = '0; end
                DIR_S:   begin x = '0; y = n; end
                DIR_NE:  begin x = m; y = m; end
                DIR_NW:  begin x = n; y = m; end
                DIR_SW:  begin x = n; y = n; end
                default: begin x = m; y = n; end
            endcase
        endfunction

        function void emit(input logic [63:0] x, input logic [63:0] y,
                           input logic last, input logic [1:0] err);
            delta_beat_t d;
            d.dx   = x;
            d.dy   = y;
            d.last = last;
            d.err  = err;
            due_deltas.push_back(d);
        endfunction

        function void finish_delta(input logic [63:0] x, input logic [63:0] y);
            deltas_left = deltas_left - 64'd1;
            if (deltas_left == '0) begin
                dec_phase = PH_TYPE;
                emit(x, y, 1'b1, ERR_NONE);
            end else begin
                dec_phase = PH_DELTA;
                emit(x, y, 1'b0, ERR_NONE);
            end
        endfunction

        function void decode_byte(input logic [7:0] b, input logic start);
            logic [63:0] v;
            logic [63:0] x;
            logic [63:0] y;
            if (start) begin
                dec_phase   = PH_TYPE;
                group_sum   = '0;
                group_shift = '0;
                deltas_left = '0;
            end
            if (dec_phase == PH_HALT) begin
                return;
            end
            group_sum = group_sum + ({57'd0, b[6:0]} << group_shift[5:0]);
            if (b[7]) begin
                if (group_shift >= 7 * (MAX_VARINT_BYTES - 1)) begin
                    dec_phase   = PH_HALT;
                    group_sum   = '0;
                    group_shift = '0;
                    n_overlong++;
                    emit('0, '0, 1'b1, ERR_OVERLONG);
                end else begin
                    group_shift = group_shift + 7'd7;
                end
                return;
            end
            v           = group_sum;
            group_sum   = '0;
            group_shift = '0;
            case (dec_phase)
                PH_TYPE: begin
                    if (v >= TYPE_LIMIT) begin
                        dec_phase = PH_HALT;
                        n_bad_type++;
                        emit('0, '0, 1'b1, ERR_BAD_TYPE);
                    end else begin
                        list_type       = v[2:0];
                        horizontal_next = (v[2:0] == TYPE_ONEAXIS_H);
                        dec_phase       = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    deltas_left = v;
                    dec_phase   = (v == '0) ? PH_TYPE : PH_DELTA;
                end
                PH_DELTA: begin
                    if (list_type <= TYPE_ONEAXIS_V) begin
                        if (horizontal_next) begin
                            x = sign_mag(v);
                            y = '0;
                        end else begin
                            x = '0;
                            y = sign_mag(v);
                        end
                        horizontal_next = ~horizontal_next;
                    end else if (list_type == TYPE_DIR2) begin
                        dir_offsets({1'b0, v[1:0]}, v >> 2, x, y);
                    end else if (list_type == TYPE_DIR3) begin
                        dir_offsets(v[2:0], v >> 3, x, y);
                    end else if (!v[0]) begin
                        dir_offsets(v[3:1], v >> 4, x, y);
                    end else begin
                        pending_dx = sign_mag(v >> 1);
                        dec_phase  = PH_DY;
                        return;
                    end
                    finish_delta(x, y);
                end
                default: begin
                    finish_delta(pending_dx, sign_mag(v));
                end
            endcase
        endfunction

        function void compare(input string field, input logic [63:0] want,
                              input logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
                n_fail++;
            end
        endfunction

        function void check_delta(input logic [63:0] dx, input logic [63:0] dy,
                                  input logic last, input logic [1:0] err);
            delta_beat_t want;
            if (due_deltas.size() == 0) begin
                $display("%0t: delta beat with none expected, expected nothing, got dx=%h dy=%h last=%b err=%0d",
                         $time, dx, dy, last, err);
                n_fail++;
                return;
            end
            want = due_deltas.pop_front();
            n_checked++;
            compare("dx", want.dx, dx);
            compare("dy", want.dy, dy);
            compare("last_delta", {63'd0, want.last}, {63'd0, last});
            compare("error_code", {62'd0, want.err}, {62'd0, err});
        endfunction
    endclass

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte  = 8'd0;
    logic               s_list_start = 1'b0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic signed [63:0] m_dx;
    logic signed [63:0] m_dy;
    logic               m_last_delta;
    logic [1:0]         m_error_code;

    delta_scoreboard    sb;
    stream_byte_t       stream_q[$];
    logic               next_start;
    logic               need_start;
    int                 lists_made;
    int                 bytes_sent;
    int                 burst_left;
    int                 cycle_count;

    point_list_delta_decoder #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_list_start(s_list_start),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dx        (m_dx),
        .m_dy        (m_dy),
        .m_last_delta(m_last_delta),
        .m_error_code(m_error_code)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_point_list_delta_decoder: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_delta(m_dx, m_dy, m_last_delta, m_error_code);
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        stream_byte_t sb_item;
        sb_item.data  = b;
        sb_item.start = next_start;
        stream_q.push_back(sb_item);
        next_start = 1'b0;
    endfunction

    function automatic void put_varint(input logic [63:0] v, input int style);
        int          nb;
        logic [63:0] r;
        logic [6:0]  g;
        nb = 1;
        r  = v >> 7;
        while (r != '0) begin
            nb++;
            r = r >> 7;
        end
        if (style == 1) begin
            nb = $urandom_range(nb, MAX_VARINT_BYTES);
        end else if (style == 2) begin
            nb = MAX_VARINT_BYTES;
        end
        r = v;
        for (int i = 0; i < nb; i++) begin
            g = r[6:0];
            r = r >> 7;
            if (style == 2 && i == MAX_VARINT_BYTES - 1) begin
                g[6:1] = 6'($urandom);
            end
            put_byte({i != nb - 1, g});
        end
    endfunction

    function automatic void put_value(input logic [63:0] v);
        int pick;
        pick = $urandom_range(0, 99);
        put_varint(v, (pick < 80) ? 0 : (pick < 92) ? 1 : 2);
    endfunction

    function automatic void put_overlong();
        for (int i = 0; i < MAX_VARINT_BYTES; i++) begin
            put_byte({1'b1, 7'($urandom)});
        end
    endfunction

    function automatic void put_noise();
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            put_byte(8'($urandom));
        end
    endfunction

    function automatic logic [63:0] rand_val();
        logic [63:0] r;
        int          w;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = $urandom_range(0, 8);
            4, 5, 6:    w = $urandom_range(9, 24);
            7, 8:       w = $urandom_range(25, 64);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 64'h8000_0000_0000_0000;
                    default: return 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
        endcase
        if (w < 64) begin
            r = r & ((64'd1 << w) - 64'd1);
        end
        return r;
    endfunction

    function automatic void put_delta(input logic [2:0] ty);
        logic [63:0] v;
        v = rand_val();
        if (ty >= TYPE_GENERAL_FIRST && ty <= TYPE_GENERAL_LAST) begin
            v[0] = 1'($urandom);
        end
        put_value(v);
        if (ty >= TYPE_GENERAL_FIRST && v[0]) begin
            put_value(rand_val());
        end
    endfunction

    function automatic void gen_list();
        int          kind;
        int          n;
        logic [2:0]  ty;
        logic [63:0] count;
        logic [63:0] v;
        kind       = $urandom_range(0, 99);
        ty         = 3'($urandom_range(0, 5));
        next_start = need_start || ($urandom_range(0, 1) == 1);
        need_start = 1'b1;
        lists_made++;
        if (kind < 6) begin
            v = rand_val();
            if (v < TYPE_LIMIT) begin
                v = v + TYPE_LIMIT;
            end
            put_value(v);
            put_noise();
            return;
        end
        if (kind == 6) begin
            put_overlong();
            put_noise();
            return;
        end
        put_value({61'd0, ty});
        if (kind == 7) begin
            put_overlong();
            put_noise();
            return;
        end
        if (kind < 16) begin
            count = rand_val();
            n     = $urandom_range(0, 3);
        end else begin
            count = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 8));
            n     = int'(count);
        end
        put_value(count);
        for (int i = 0; i < n; i++) begin
            put_delta(ty);
        end
        if (kind < 12) begin
            put_overlong();
            put_noise();
        end else if (kind < 16) begin
            if ($urandom_range(0, 1) == 1) begin
                put_byte({1'b1, 7'($urandom)});
            end
        end else begin
            need_start = 1'b0;
        end
    endfunction

    task automatic send_bytes(input int n);
        stream_byte_t item;
        int           gap;
        for (int i = 0; i < n && stream_q.size() > 0; i++) begin
            item = stream_q.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
            burst_left--;
            @(negedge aclk);
            s_valid      <= 1'b1;
            s_data_byte  <= item.data;
            s_list_start <= item.start;
            do @(posedge aclk); while (!s_ready);
            sb.decode_byte(item.data, item.start);
            bytes_sent++;
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.outstanding() > 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int cyc;
        int stretch;
        int mode;
        cyc     = 0;
        stretch = 0;
        mode    = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) begin
                m_ready <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 150);
                end
                stretch--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 9) >= 3);
                    2:       m_ready <= ($urandom_range(0, 9) >= 7);
                    default: m_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        sb          = new();
        lists_made  = 0;
        bytes_sent  = 0;
        burst_left  = 0;
        cycle_count = 0;
        need_start  = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // One-axis list, zero count, two-bit directions, a general pair, a
        // general direction cut off by a new list with a bad type, bytes
        // dropped while halted, and an overlong varint.
        next_start = 1'b1;
        put_byte(8'h00); put_byte(8'h02); put_byte(8'h03); put_byte(8'h04);
        put_byte(8'h01); put_byte(8'h00);
        put_byte(8'h02); put_byte(8'h02); put_byte(8'h7E); put_byte(8'h7F);
        put_byte(8'h05); put_byte(8'h01); put_byte(8'h07); put_byte(8'h05);
        put_byte(8'h04); put_byte(8'h02); put_byte(8'h1C);
        next_start = 1'b1;
        put_byte(8'h06); put_byte(8'hFF);
        next_start = 1'b1;
        for (int i = 0; i < MAX_VARINT_BYTES; i++) begin
            put_byte(8'hFF);
        end
        lists_made = 7;
        send_bytes(stream_q.size());
        wait_drained();

        while (stream_q.size() < RANDOM_BYTES) begin
            gen_list();
        end
        send_bytes(stream_q.size() / 2);
        wait_drained();
        send_bytes(stream_q.size());
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in about %0d point lists of all six types.",
                 bytes_sent, lists_made);
        $display("Checked %0d delta beats, %0d bad types and %0d overlong varints.",
                 sb.n_checked, sb.n_bad_type, sb.n_overlong);
        if (sb.n_fail == 0 && sb.outstanding() == 0) begin
            $display("tb_point_list_delta_decoder: done, clean");
        end else begin
            $display("tb_point_list_delta_decoder: done, errors");
        end
        $finish;
    end

endmodule
